// File: rtl/lljd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lljd_pkg
// Shared sizes, result codes and the command word of the job dispatcher.
// ----------------------------------------------------------------------------
package lljd_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int WINDOW_COUNT  = 8;

  localparam int PTR_W  = $clog2(PENDING_DEPTH);
  localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
  localparam int WCNT_W = $clog2(WINDOW_COUNT + 1);

  localparam int TICKET_W = 10;
  localparam int DUR_W    = 16;
  localparam int LOAD_W   = 32;
  localparam int WIN_W    = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_W    = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICKET_W-1:0] TICKET_MODULUS = TICKET_W'(1000);
  localparam logic [CFG_W-1:0]    ACTIVE_RESET   = CFG_W'(8);

  localparam logic MODE_ENQUEUE    = 1'b0;
  localparam logic MODE_DISTRIBUTE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TOTAL   = 2'd3;

  typedef struct packed {
    logic                mode;
    logic [TICKET_W-1:0] ticket;
    logic [DUR_W-1:0]    duration;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/lljd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lljd_front
// Input stage: takes a word, reduces the ticket modulo 1000 and registers the
// command for the queue.
// ----------------------------------------------------------------------------
module lljd_front
  import lljd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_mode,
  input  wire logic [TICKET_W-1:0] in_ticket,
  input  wire logic [DUR_W-1:0]    in_duration,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output cmd_t                     cmd
);

  logic [TICKET_W-1:0] ticket_red;

  // Ticket is below 1024, so one subtract is enough.
  assign ticket_red = (in_ticket >= TICKET_MODULUS) ? (in_ticket - TICKET_MODULUS)
                                                    : in_ticket;

  assign in_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd.mode     <= in_mode;
      cmd.ticket   <= ticket_red;
      cmd.duration <= in_duration;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lljd_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lljd_cmd_queue
// Short command queue between the input stage and the dispatch engine.
// ----------------------------------------------------------------------------
module lljd_cmd_queue
  import lljd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_cmd
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lljd_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lljd_engine
// Dispatch engine: owns the pending job memory and the window loads, stores
// enqueued jobs and drains them to the least loaded window on a distribute.
// ----------------------------------------------------------------------------
module lljd_engine
  import lljd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  cmd_t                     cmd,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [KIND_W-1:0]        out_kind,
  output logic [TICKET_W-1:0]      out_ticket,
  output logic [WIN_W-1:0]         out_window,
  output logic [LOAD_W-1:0]        out_load,
  output logic                     out_last
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_ASSIGN = 3'd3;
  localparam logic [2:0] ST_TOTAL  = 3'd4;

  logic [2:0]                  state;
  logic [CFG_W-1:0]            active_cfg;
  logic [WCNT_W-1:0]           n_active;
  logic [WCNT_W-1:0]           n_clamped;
  logic [WCNT_W-1:0]           scan;
  logic [WIN_W-1:0]            best;
  logic [LOAD_W-1:0]           best_load;
  logic [LOAD_W-1:0]           loads [WINDOW_COUNT];
  logic [LOAD_W-1:0]           scan_load;
  logic [PTR_W-1:0]            head;
  logic [CNT_W-1:0]            count;
  logic [CNT_W:0]              tail_sum;
  logic [PTR_W-1:0]            tail;
  logic [TICKET_W+DUR_W-1:0]   mem [PENDING_DEPTH];
  logic [TICKET_W+DUR_W-1:0]   rd_data;
  logic [TICKET_W-1:0]         job_ticket;
  logic [DUR_W-1:0]            job_dur;
  logic [LOAD_W:0]             sum_wide;
  logic [LOAD_W-1:0]           sum_sat;
  logic                        out_free;
  logic                        full;
  logic                        total_last;
  logic                        emit;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign full      = (count == CNT_W'(PENDING_DEPTH));

  // A new output word is loaded in this cycle.
  assign emit = ((state == ST_IDLE) && cmd_valid && cmd_ready && (cmd.mode == MODE_ENQUEUE))
             || ((state inside {ST_ASSIGN, ST_TOTAL}) && out_free);

  assign tail_sum = {1'b0, count} + (CNT_W + 1)'(head);
  assign tail     = (tail_sum >= (CNT_W + 1)'(PENDING_DEPTH))
                    ? PTR_W'(tail_sum - (CNT_W + 1)'(PENDING_DEPTH))
                    : PTR_W'(tail_sum);

  assign n_clamped = (active_cfg == '0) ? WCNT_W'(1)
                   : (active_cfg > CFG_W'(WINDOW_COUNT)) ? WCNT_W'(WINDOW_COUNT)
                   : WCNT_W'(active_cfg);

  assign scan_load  = loads[scan[WIN_W-1:0]];
  assign job_ticket = rd_data[TICKET_W+DUR_W-1:DUR_W];
  assign job_dur    = rd_data[DUR_W-1:0];
  assign sum_wide   = {1'b0, best_load} + (LOAD_W + 1)'(job_dur);
  assign sum_sat    = sum_wide[LOAD_W] ? '1 : sum_wide[LOAD_W-1:0];
  assign total_last = ((scan + WCNT_W'(1)) == n_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cfg <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_cfg <= cfg_data;
    end
  end

  // Pending job memory; read data is only taken while fetching a job.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.mode == MODE_ENQUEUE && !full) begin
      mem[tail] <= {cmd.ticket, cmd.duration};
    end
    if (state == ST_READ) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      n_active  <= '0;
      scan      <= '0;
      best      <= '0;
      best_load <= '0;
      for (int i = 0; i < WINDOW_COUNT; i++) begin
        loads[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            if (cmd.mode == MODE_ENQUEUE) begin
              out_kind   <= full ? KIND_DROPPED : KIND_ACCEPT;
              out_ticket <= cmd.ticket;
              out_window <= '0;
              out_load   <= '0;
              out_last   <= 1'b1;
              if (!full) begin
                count <= count + CNT_W'(1);
              end
            end else begin
              n_active <= n_clamped;
              scan     <= '0;
              state    <= (count != '0) ? ST_READ : ST_TOTAL;
            end
          end
        end
        ST_READ: begin
          head      <= (head == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head + PTR_W'(1);
          count     <= count - CNT_W'(1);
          best      <= '0;
          best_load <= loads[0];
          scan      <= WCNT_W'(1);
          state     <= ST_SCAN;
        end
        ST_SCAN: begin
          // One window compared per cycle; strict less keeps the lowest index.
          if (scan < n_active) begin
            if (scan_load < best_load) begin
              best      <= scan[WIN_W-1:0];
              best_load <= scan_load;
            end
            scan <= scan + WCNT_W'(1);
          end else begin
            state <= ST_ASSIGN;
          end
        end
        ST_ASSIGN: begin
          if (out_free) begin
            loads[best] <= sum_sat;
            out_kind    <= KIND_ASSIGN;
            out_ticket  <= job_ticket;
            out_window  <= best;
            out_load    <= sum_sat;
            out_last    <= 1'b0;
            scan        <= '0;
            state       <= (count != '0) ? ST_READ : ST_TOTAL;
          end
        end
        ST_TOTAL: begin
          if (out_free) begin
            out_kind   <= KIND_TOTAL;
            out_ticket <= '0;
            out_window <= scan[WIN_W-1:0];
            out_load   <= scan_load;
            out_last   <= total_last;
            scan       <= scan + WCNT_W'(1);
            if (total_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/least_loaded_job_dispatcher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher
// Queues jobs and hands them to the least loaded of the active windows.
// ----------------------------------------------------------------------------
// An enqueue word (tuser 0) stores the job in a 32-entry pending memory and
// returns one accepted or dropped word. A distribute word (tuser 1) drains the
// pending jobs in order, giving one assignment word per job, then one total
// word per active window, the last marked with tlast. The input stage and a
// two-entry command queue keep taking words while the engine works. For a
// distribute the engine takes the command, and for each job does one memory
// read, walks the active windows with the single load comparator one per
// cycle, and does one update; then it sends the totals. New commands and the
// assignment and total words wait while the output is stalled. Loads are kept
// across distributes and saturate at 2^32-1. The active window count is
// written through the cfg port; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module least_loaded_job_dispatcher
  import lljd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // ticket[9:0], duration[25:10]
  input  wire logic                  s_axis_tuser,   // mode
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // ticket_out[9:0], window[12:10],
                                                     // load[44:13]
  output logic [KIND_W-1:0]          m_axis_tuser,   // kind
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  cmd_t                front_cmd;
  logic                front_valid;
  logic                front_ready;
  cmd_t                q_cmd;
  logic                q_valid;
  logic                q_ready;
  logic [TICKET_W-1:0] out_ticket;
  logic [WIN_W-1:0]    out_window;
  logic [LOAD_W-1:0]   out_load;

  lljd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_mode     (s_axis_tuser),
    .in_ticket   (s_axis_tdata[TICKET_W-1:0]),
    .in_duration (s_axis_tdata[TICKET_W+DUR_W-1:TICKET_W]),
    .cmd_valid   (front_valid),
    .cmd_ready   (front_ready),
    .cmd         (front_cmd)
  );

  lljd_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  lljd_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_ticket (out_ticket),
    .out_window (out_window),
    .out_load   (out_load),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_DATA_W - TICKET_W - WIN_W - LOAD_W)'(0),
                         out_load, out_window, out_ticket};

endmodule
`default_nettype wire

// File: tb/lljd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lljd_checker
// Watches the command, result and cfg channels of the job dispatcher. It keeps
// its own copy of the pending jobs, the window loads and the active window
// count. It works out the result words that each accepted command owes and
// compares every accepted result word with the oldest one still owed.
// ----------------------------------------------------------------------------
module lljd_checker
  import lljd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                  s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic [KIND_W-1:0]     m_axis_tuser,
  input  wire logic                  m_axis_tlast,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output int                         mismatches,
  output int                         words_owed
);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TICKET_W-1:0] ticket;
    logic [WIN_W-1:0]    window;
    logic [LOAD_W-1:0]   load;
    logic                last;
  } result_t;

  result_t             owed_words[$];
  logic [TICKET_W-1:0] queued_tickets[$];
  logic [DUR_W-1:0]    queued_durations[$];
  logic [LOAD_W-1:0]   window_load[WINDOW_COUNT];
  logic [CFG_W-1:0]    active_setting;
  int                  error_total = 0;

  initial begin
    mismatches = 0;
    words_owed = 0;
  end

  task automatic report_mismatch(input string what);
    error_total++;
    $display("%0t ns: dispatcher mismatch: %s", $time, what);
  endtask

  function automatic result_t make_word(input logic [KIND_W-1:0] kind,
                                        input logic [TICKET_W-1:0] ticket,
                                        input logic [WIN_W-1:0] window,
                                        input logic [LOAD_W-1:0] load,
                                        input logic last);
    result_t word;
    word.kind   = kind;
    word.ticket = ticket;
    word.window = window;
    word.load   = load;
    word.last   = last;
    return word;
  endfunction

  // Appends one word to the list of words still owed.
  task automatic owe_word(input result_t word);
    owed_words.insert(owed_words.size(), word);
  endtask

  // Works out every result word that one command causes and updates the
  // job queue and the window loads to match.
  task automatic dispatch_command(input logic mode,
                                  input logic [TICKET_W-1:0] ticket,
                                  input logic [DUR_W-1:0] duration);
    int                  windows;
    int                  best;
    logic [LOAD_W:0]     sum;
    logic [TICKET_W-1:0] tk;
    logic [DUR_W-1:0]    dur;
    windows = active_setting;
    if (windows < 1) windows = 1;
    if (windows > WINDOW_COUNT) windows = WINDOW_COUNT;
    if (mode == MODE_ENQUEUE) begin
      tk = ticket % TICKET_MODULUS;
      if (queued_tickets.size() >= PENDING_DEPTH) begin
        owe_word(make_word(KIND_DROPPED, tk, '0, '0, 1'b1));
      end else begin
        queued_tickets.insert(queued_tickets.size(), tk);
        queued_durations.insert(queued_durations.size(), duration);
        owe_word(make_word(KIND_ACCEPT, tk, '0, '0, 1'b1));
      end
    end else begin
      while (queued_tickets.size() > 0) begin
        tk = queued_tickets.pop_front();
        dur = queued_durations.pop_front();
        best = 0;
        // Strictly smaller wins, so ties stay with the lowest index.
        for (int w = 1; w < windows; w++) begin
          if (window_load[w] < window_load[best]) best = w;
        end
        sum = {1'b0, window_load[best]} + dur;
        window_load[best] = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
        owe_word(make_word(KIND_ASSIGN, tk, WIN_W'(best), window_load[best], 1'b0));
      end
      for (int w = 0; w < windows; w++) begin
        owe_word(make_word(KIND_TOTAL, '0, WIN_W'(w), window_load[w], w == windows - 1));
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t seen;
    result_t want;
    string   diffs;
    if (rst) begin
      owed_words.delete();
      queued_tickets.delete();
      queued_durations.delete();
      for (int w = 0; w < WINDOW_COUNT; w++) window_load[w] = '0;
      active_setting = ACTIVE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) active_setting = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        dispatch_command(s_axis_tuser, s_axis_tdata[TICKET_W-1:0],
                         s_axis_tdata[TICKET_W +: DUR_W]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = make_word(m_axis_tuser, m_axis_tdata[TICKET_W-1:0],
                         m_axis_tdata[TICKET_W +: WIN_W],
                         m_axis_tdata[TICKET_W+WIN_W +: LOAD_W], m_axis_tlast);
        if (owed_words.size() == 0) begin
          report_mismatch($sformatf("result word kind %0d with nothing owed", seen.kind));
        end else begin
          want = owed_words.pop_front();
          diffs = "";
          if (seen.kind !== want.kind)
            diffs = {diffs, $sformatf(" kind %0d/%0d", seen.kind, want.kind)};
          if (seen.ticket !== want.ticket)
            diffs = {diffs, $sformatf(" ticket %0d/%0d", seen.ticket, want.ticket)};
          if (seen.window !== want.window)
            diffs = {diffs, $sformatf(" window %0d/%0d", seen.window, want.window)};
          if (seen.load !== want.load)
            diffs = {diffs, $sformatf(" load %0d/%0d", seen.load, want.load)};
          if (seen.last !== want.last)
            diffs = {diffs, $sformatf(" last %0d/%0d", seen.last, want.last)};
          if (diffs != "") report_mismatch({"got/expected", diffs});
        end
      end
    end
    mismatches <= error_total;
    words_owed <= owed_words.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the least loaded job dispatcher. A directed opening covers the
// field extremes, ticket wrap, zero durations, empty distributes and the
// clamped window counts. Random job batches under bursty input and a
// stalling output follow, with one long output hold-off and queue overflows.
// ----------------------------------------------------------------------------
module tb;
  import lljd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  wire                   s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  wire                   m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  wire [OUT_DATA_W-1:0]  m_axis_tdata;
  wire [KIND_W-1:0]      m_axis_tuser;
  wire                   m_axis_tlast;
  logic                  cfg_valid = 1'b0;
  wire                   cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;
  int                    mismatches;
  int                    words_owed;

  // Sender and receiver pacing.
  bit tx_steady = 1'b0;
  int burst_left = 0;
  int words_sent = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int run_left = 0;

  always #2 clk = ~clk;

  least_loaded_job_dispatcher uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  lljd_checker chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .words_owed   (words_owed)
  );

  // Result side: alternating ready and stall runs of random length, an
  // occasional long ready stretch, and a long hold-off when asked for.
  always @(posedge clk) begin
    if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = 300;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (run_left > 0) begin
      run_left--;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      run_left = $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
      run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
    end
  end

  // Offers one command word and returns at the edge where it is taken, or after any gap that follows. The
  // valid stays high unless a gap follows, so a caller must either send the
  // next word or call settle before time moves on.
  task automatic send_word(input logic mode, input logic [TICKET_W-1:0] ticket,
                           input logic [DUR_W-1:0] duration);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= IN_DATA_W'({duration, ticket});
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (!tx_steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 5);
      end
    end
  endtask

  // Stops offering and waits until every owed result word has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (words_owed != 0);
  endtask

  task automatic set_windows(input logic [CFG_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A run of enqueues with mixed durations, closed by a distribute whose
  // ticket and duration bits are random noise.
  task automatic job_batch(input int jobs);
    logic [DUR_W-1:0] dur;
    for (int j = 0; j < jobs; j++) begin
      case ($urandom_range(0, 5))
        0:       dur = '0;
        1:       dur = '1;
        2:       dur = DUR_W'($urandom_range(1, 50));
        default: dur = DUR_W'($urandom_range(0, 65535));
      endcase
      send_word(MODE_ENQUEUE, TICKET_W'($urandom_range(0, 1023)), dur);
    end
    send_word(MODE_DISTRIBUTE, TICKET_W'($urandom_range(0, 1023)),
              DUR_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    int start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed opening, all eight windows active after reset.
    send_word(MODE_DISTRIBUTE, 10'd1023, 16'hFFFF);
    send_word(MODE_ENQUEUE, 10'd0, 16'd0);
    send_word(MODE_ENQUEUE, 10'd999, 16'hFFFF);
    send_word(MODE_ENQUEUE, 10'd1000, 16'd1);
    send_word(MODE_ENQUEUE, 10'd1023, 16'hAAAA);
    send_word(MODE_ENQUEUE, 10'd511, 16'h5555);
    send_word(MODE_ENQUEUE, 10'd1, 16'hFFFF);
    send_word(MODE_DISTRIBUTE, 10'd0, 16'd0);
    // A count of zero acts as one window, fifteen as all of them.
    set_windows(4'd0);
    send_word(MODE_ENQUEUE, 10'd7, 16'd100);
    send_word(MODE_ENQUEUE, 10'd8, 16'd200);
    send_word(MODE_DISTRIBUTE, 10'd512, 16'h8000);
    set_windows(4'd15);
    send_word(MODE_ENQUEUE, 10'd3, 16'hFFFF);
    send_word(MODE_DISTRIBUTE, 10'd0, 16'd0);
    set_windows(4'd3);
    send_word(MODE_ENQUEUE, 10'd500, 16'd0);
    send_word(MODE_ENQUEUE, 10'd1001, 16'd7);
    send_word(MODE_DISTRIBUTE, 10'd0, 16'd0);

    // Random phases, each with its own window count.
    for (int phase = 0; phase < 3; phase++) begin
      set_windows(CFG_W'($urandom_range(0, 15)));
      start = words_sent;
      if (phase == 1) begin
        // Overflow the pending queue so later enqueues are dropped.
        job_batch(36);
      end
      if (phase == 2) begin
        // Hold the result side off while commands keep coming.
        holds_asked <= holds_asked + 1;
        tx_steady = 1'b1;
        job_batch(14);
        tx_steady = 1'b0;
      end
      while (words_sent - start < 28) begin
        case ($urandom_range(0, 9))
          0: send_word(MODE_DISTRIBUTE, TICKET_W'($urandom_range(0, 1023)),
                       DUR_W'($urandom_range(0, 65535)));
          1: begin
            // Jobs left pending for a later distribute.
            repeat ($urandom_range(1, 4)) begin
              send_word(MODE_ENQUEUE, TICKET_W'($urandom_range(0, 1023)),
                        DUR_W'($urandom_range(0, 65535)));
            end
          end
          default: job_batch($urandom_range(0, 10));
        endcase
      end
    end

    set_windows(4'd8);
    job_batch(10);
    set_windows(4'd2);
    job_batch(6);

    settle();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("least_loaded_job_dispatcher test passed");
    end else begin
      $display("least_loaded_job_dispatcher test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("least_loaded_job_dispatcher test failed");
    $finish;
  end

endmodule
